[design/email_address_validator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the email address validator.
// ----------------------------------------------------------------------------
`ifndef EMAIL_ADDRESS_VALIDATOR_MACROS_SVH
`define EMAIL_ADDRESS_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define EAV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("eav assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define EAV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("eav assertion failed");
`else
`define EAV_ASSERT_SAME(label, ante, cons)
`define EAV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/eav_pkg.sv]
// ----------------------------------------------------------------------------
// eav_pkg
// Types, phase codes and character classes shared by the validator modules.
// ----------------------------------------------------------------------------
package eav_pkg;

    localparam logic [2:0] PH_LOCAL  = 3'd0;
    localparam logic [2:0] PH_QUOTED = 3'd1;
    localparam logic [2:0] PH_ESCAPE = 3'd2;
    localparam logic [2:0] PH_CLOSED = 3'd3;
    localparam logic [2:0] PH_DOMAIN = 3'd4;
    localparam logic [2:0] PH_REJECT = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef struct packed {
        logic [2:0] phase;
        logic       at_local_start;
        logic       prev_was_dot;
        logic       domain_has_dot;
        logic       at_domain_start;
    } eav_state_t;

    localparam eav_state_t STATE_RESET = '{
        phase:           PH_LOCAL,
        at_local_start:  1'b1,
        prev_was_dot:    1'b0,
        domain_has_dot:  1'b0,
        at_domain_start: 1'b0
    };

    function automatic logic is_special(input logic [7:0] b);
        logic res;
        case (b) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C,
            8'h3B, 8'h3A, 8'h5C, 8'h22, 8'h5B, 8'h5D: res = 1'b1;
            default:                                 res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic out_of_range(input logic [7:0] b);
        return (b <= CH_SPACE) || (b >= CH_DEL);
    endfunction

endpackage

[design/eav_parser.sv]
// ----------------------------------------------------------------------------
// eav_parser
// Next-state and verdict logic for one address byte.
// ----------------------------------------------------------------------------
module eav_parser (
    input  logic [7:0]          char_byte,
    input  eav_pkg::eav_state_t cur,
    output eav_pkg::eav_state_t nxt,
    output logic                verdict
);

    logic bad_char;
    logic local_edge;

    assign bad_char   = eav_pkg::out_of_range(char_byte) || eav_pkg::is_special(char_byte);
    assign local_edge = cur.at_local_start || cur.prev_was_dot;
    assign verdict    = (cur.phase == eav_pkg::PH_DOMAIN) && !cur.at_domain_start &&
                        cur.domain_has_dot;

    always_comb begin
        nxt = cur;
        if (char_byte == eav_pkg::CH_NUL) begin
            nxt = eav_pkg::STATE_RESET;
        end else begin
            unique case (cur.phase)
                eav_pkg::PH_LOCAL: begin
                    if (char_byte == eav_pkg::CH_QUOTE && local_edge) begin
                        nxt.phase          = eav_pkg::PH_QUOTED;
                        nxt.at_local_start = 1'b0;
                        nxt.prev_was_dot   = 1'b0;
                    end else if (char_byte == eav_pkg::CH_AT) begin
                        if (local_edge) begin
                            nxt.phase = eav_pkg::PH_REJECT;
                        end else begin
                            nxt.phase           = eav_pkg::PH_DOMAIN;
                            nxt.at_domain_start = 1'b1;
                            nxt.prev_was_dot    = 1'b0;
                            nxt.domain_has_dot  = 1'b0;
                        end
                    end else if (bad_char) begin
                        nxt.phase = eav_pkg::PH_REJECT;
                    end else begin
                        nxt.at_local_start = 1'b0;
                        nxt.prev_was_dot   = (char_byte == eav_pkg::CH_DOT);
                    end
                end
                eav_pkg::PH_QUOTED: begin
                    if (char_byte == eav_pkg::CH_QUOTE) begin
                        nxt.phase = eav_pkg::PH_CLOSED;
                    end else if (char_byte == eav_pkg::CH_BSLASH) begin
                        nxt.phase = eav_pkg::PH_ESCAPE;
                    end else if (eav_pkg::out_of_range(char_byte)) begin
                        nxt.phase = eav_pkg::PH_REJECT;
                    end
                end
                eav_pkg::PH_ESCAPE: begin
                    // An escaped space is allowed even though a bare one is not.
                    if (char_byte == eav_pkg::CH_SPACE || !eav_pkg::out_of_range(char_byte)) begin
                        nxt.phase = eav_pkg::PH_QUOTED;
                    end else begin
                        nxt.phase = eav_pkg::PH_REJECT;
                    end
                end
                eav_pkg::PH_CLOSED: begin
                    if (char_byte == eav_pkg::CH_AT) begin
                        nxt.phase           = eav_pkg::PH_DOMAIN;
                        nxt.at_domain_start = 1'b1;
                        nxt.prev_was_dot    = 1'b0;
                        nxt.domain_has_dot  = 1'b0;
                    end else if (char_byte == eav_pkg::CH_DOT) begin
                        nxt.phase          = eav_pkg::PH_LOCAL;
                        nxt.at_local_start = 1'b0;
                        nxt.prev_was_dot   = 1'b1;
                    end else begin
                        nxt.phase = eav_pkg::PH_REJECT;
                    end
                end
                eav_pkg::PH_DOMAIN: begin
                    if (char_byte == eav_pkg::CH_DOT) begin
                        if (cur.at_domain_start || cur.prev_was_dot) begin
                            nxt.phase = eav_pkg::PH_REJECT;
                        end else begin
                            nxt.domain_has_dot  = 1'b1;
                            nxt.prev_was_dot    = 1'b1;
                            nxt.at_domain_start = 1'b0;
                        end
                    end else if (bad_char) begin
                        nxt.phase = eav_pkg::PH_REJECT;
                    end else begin
                        nxt.prev_was_dot    = 1'b0;
                        nxt.at_domain_start = 1'b0;
                    end
                end
                default: begin
                    nxt.phase = eav_pkg::PH_REJECT;
                end
            endcase
        end
    end

endmodule

[design/email_address_validator.sv]
// ----------------------------------------------------------------------------
// email_address_validator
// Streams address bytes in and returns one verdict per zero-terminated address.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of an address enter on the s_ channel, one item per cycle at most.
// A zero byte ends the address; it yields one item on the m_ channel whose
// m_address_ok is 1 when the address was valid. Nonzero bytes yield nothing.
// After the zero byte the parser is back in its start state, so the next
// address may follow in the very next cycle.
// A zero byte is held first in the input register and its verdict then in the
// result register on m_valid (two register stages: input byte, then result).
// Throughput: one byte per cycle while no zero byte waits for the result register.
// When the receiver stalls, nonzero bytes still flow; only a zero byte waits
// in the input register until the result register is free, and s_ready drops
// while it waits there.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of the local part.
// ----------------------------------------------------------------------------
`include "email_address_validator_macros.svh"

module email_address_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_address_ok
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    eav_pkg::eav_state_t state_reg;
    eav_pkg::eav_state_t state_next;
    logic                verdict;
    logic                m_valid_reg;
    logic                m_ok_reg;
    logic                out_free;
    logic                is_end;
    logic                proc_fire;
    logic                out_load;

    eav_parser u_parser (
        .char_byte (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .verdict   (verdict)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign is_end    = (in_byte_reg == eav_pkg::CH_NUL);
    assign proc_fire = in_valid_reg && (!is_end || out_free);
    assign out_load  = proc_fire && is_end;
    assign s_ready   = !in_valid_reg || proc_fire;

    assign m_valid      = m_valid_reg;
    assign m_address_ok = m_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= eav_pkg::STATE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                state_reg <= state_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_char_byte;
        end
        if (out_load) begin
            m_ok_reg <= verdict;
        end
    end

    // An address end always leaves the parser in its start state.
    `EAV_ASSERT_NEXT(a_end_resets, out_load, state_reg == eav_pkg::STATE_RESET)
    // A pending byte that is not processed stays in the input register.
    `EAV_ASSERT_NEXT(a_hold_input, in_valid_reg && !proc_fire,
                     in_valid_reg && $stable(in_byte_reg))
    // A positive verdict only comes from the domain phase.
    `EAV_ASSERT_SAME(a_ok_in_domain, out_load && verdict,
                     state_reg.phase == eav_pkg::PH_DOMAIN)
    // A result is never overwritten while the receiver stalls.
    `EAV_ASSERT_SAME(a_no_overwrite, out_load, !m_valid_reg || m_ready)

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the email address validator by streaming address bytes through its
// input channel and comparing every verdict with a fixed value or a built-in address parser.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int ITEM_TARGET    = 1950;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_NS     = 8_000_000;
    localparam int USE_PREDICTION = -1;
    localparam int DIR_ROWS       = 25;

    typedef struct packed {
        logic [2:0] phase;
        logic       local_start;
        logic       prev_dot;
        logic       dom_dot;
        logic       dom_start;
    } addr_state_t;

    localparam addr_state_t ADDR_START = '{eav_pkg::PH_LOCAL, 1'b1, 1'b0, 1'b0, 1'b0};

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_address_ok;

    addr_state_t addr_st = ADDR_START;
    logic        verdict_q[$];
    logic [7:0]  addr_buf[$];
    int          useful_bytes  = 0;
    int          verdicts_seen = 0;
    int          valid_seen    = 0;
    int          fail_count    = 0;
    bit          idle_on       = 1'b0;
    bit          hold_req      = 1'b0;

    // Directed addresses; a verdict of USE_PREDICTION leaves it to the parser.
    string dir_text [DIR_ROWS] = '{
        "",
        "a@b.c",
        "abc",
        "a.@b.c",
        "@b.c",
        "a@.b",
        "a@b..c",
        "a@bc",
        "a@b.c.",
        "\"x\\ y\"@d.e",
        "\"ab",
        "\"a\\",
        "x.\"q\".y@d.e",
        "\"q\"z@d.e",
        "a(b@c.d",
        "~!\377@a.b",
        "\041\176@\176.\041",
        "a\177@b.c",
        "a @b.c",
        "\"\001\"@b.c",
        "\"\\\377\"@b.c",
        "\"\\\"\"@b.c",
        "a\"b\"@c.d",
        "a@b.c@d",
        "\"\"@b.c"
    };
    int dir_verdict [DIR_ROWS] = '{
        0, 1, 0, USE_PREDICTION, USE_PREDICTION,
        USE_PREDICTION, USE_PREDICTION, USE_PREDICTION, USE_PREDICTION, USE_PREDICTION,
        USE_PREDICTION, USE_PREDICTION, USE_PREDICTION, USE_PREDICTION, USE_PREDICTION,
        0, 1, 0, USE_PREDICTION, USE_PREDICTION,
        USE_PREDICTION, USE_PREDICTION, USE_PREDICTION, USE_PREDICTION, USE_PREDICTION
    };

    email_address_validator u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_byte  (s_char_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_address_ok (m_address_ok)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic is_delim(input logic [7:0] b);
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "[", "]": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic bad_range(input logic [7:0] b);
        return (b <= eav_pkg::CH_SPACE) || (b >= eav_pkg::CH_DEL);
    endfunction

    // Advances the address parser by one byte; returns 1 when a verdict is due.
    function automatic logic step_parser(input logic [7:0] b, output logic ok);
        ok = 1'b0;
        if (b == eav_pkg::CH_NUL) begin
            ok = (addr_st.phase == eav_pkg::PH_DOMAIN) && !addr_st.dom_start &&
                 addr_st.dom_dot;
            addr_st = ADDR_START;
            return 1'b1;
        end
        case (addr_st.phase)
            eav_pkg::PH_LOCAL: begin
                if (b == eav_pkg::CH_QUOTE && (addr_st.local_start || addr_st.prev_dot)) begin
                    addr_st.phase = eav_pkg::PH_QUOTED;
                    addr_st.local_start = 1'b0;
                    addr_st.prev_dot = 1'b0;
                end else if (b == eav_pkg::CH_AT) begin
                    if (addr_st.local_start || addr_st.prev_dot) begin
                        addr_st.phase = eav_pkg::PH_REJECT;
                    end else begin
                        addr_st = '{eav_pkg::PH_DOMAIN, addr_st.local_start,
                                    1'b0, 1'b0, 1'b1};
                    end
                end else if (bad_range(b) || is_delim(b)) begin
                    addr_st.phase = eav_pkg::PH_REJECT;
                end else begin
                    addr_st.local_start = 1'b0;
                    addr_st.prev_dot = (b == eav_pkg::CH_DOT);
                end
            end
            eav_pkg::PH_QUOTED: begin
                if (b == eav_pkg::CH_QUOTE) begin
                    addr_st.phase = eav_pkg::PH_CLOSED;
                end else if (b == eav_pkg::CH_BSLASH) begin
                    addr_st.phase = eav_pkg::PH_ESCAPE;
                end else if (bad_range(b)) begin
                    addr_st.phase = eav_pkg::PH_REJECT;
                end
            end
            eav_pkg::PH_ESCAPE: begin
                addr_st.phase = (b == eav_pkg::CH_SPACE || !bad_range(b)) ?
                                eav_pkg::PH_QUOTED : eav_pkg::PH_REJECT;
            end
            eav_pkg::PH_CLOSED: begin
                if (b == eav_pkg::CH_AT) begin
                    addr_st = '{eav_pkg::PH_DOMAIN, addr_st.local_start, 1'b0, 1'b0, 1'b1};
                end else if (b == eav_pkg::CH_DOT) begin
                    addr_st.phase = eav_pkg::PH_LOCAL;
                    addr_st.local_start = 1'b0;
                    addr_st.prev_dot = 1'b1;
                end else begin
                    addr_st.phase = eav_pkg::PH_REJECT;
                end
            end
            eav_pkg::PH_DOMAIN: begin
                if (b == eav_pkg::CH_DOT) begin
                    if (addr_st.dom_start || addr_st.prev_dot) begin
                        addr_st.phase = eav_pkg::PH_REJECT;
                    end else begin
                        addr_st.dom_dot = 1'b1;
                        addr_st.prev_dot = 1'b1;
                        addr_st.dom_start = 1'b0;
                    end
                end else if (bad_range(b) || is_delim(b)) begin
                    addr_st.phase = eav_pkg::PH_REJECT;
                end else begin
                    addr_st.prev_dot = 1'b0;
                    addr_st.dom_start = 1'b0;
                end
            end
            default: begin
                addr_st.phase = eav_pkg::PH_REJECT;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_atom_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(33, 126));
        end while (is_delim(c) || c == eav_pkg::CH_DOT);
        return c;
    endfunction

    task automatic flag_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // Offers one byte, with an occasional idle burst first, and predicts on accept.
    task automatic send_byte(input logic [7:0] b, input int fixed_verdict);
        logic got;
        logic ok;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        useful_bytes++;
        got = step_parser(b, ok);
        if (got) begin
            verdict_q.push_back(fixed_verdict == USE_PREDICTION ? ok : fixed_verdict[0]);
        end
    endtask

    task automatic send_address(input int fixed_verdict);
        foreach (addr_buf[i]) begin
            send_byte(addr_buf[i], USE_PREDICTION);
        end
        send_byte(eav_pkg::CH_NUL, fixed_verdict);
    endtask

    task automatic wait_for_verdicts();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (verdict_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // Mostly well-formed addresses with random content; some get one defect,
    // a few are plain byte noise.
    task automatic compose_address();
        string      specials;
        int         kind;
        int         atoms;
        int         labels;
        int         len;
        int         pos;
        int         i;
        int         j;
        logic [7:0] c;
        specials = "()<>@,;:\\\"[]";
        addr_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(0, 12);
            repeat (len) addr_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        atoms = $urandom_range(1, 3);
        for (i = 0; i < atoms; i++) begin
            if (i > 0) begin
                addr_buf.push_back(eav_pkg::CH_DOT);
            end
            if ($urandom_range(0, 3) == 0) begin
                addr_buf.push_back(eav_pkg::CH_QUOTE);
                len = $urandom_range(0, 4);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        addr_buf.push_back(eav_pkg::CH_BSLASH);
                        case ($urandom_range(0, 3))
                            0:       c = eav_pkg::CH_SPACE;
                            1:       c = 8'($urandom_range(1, 255));
                            default: c = 8'($urandom_range(33, 126));
                        endcase
                    end else begin
                        do begin
                            c = 8'($urandom_range(33, 126));
                        end while (c == eav_pkg::CH_QUOTE || c == eav_pkg::CH_BSLASH);
                    end
                    addr_buf.push_back(c);
                end
                addr_buf.push_back(eav_pkg::CH_QUOTE);
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) addr_buf.push_back(pick_atom_char());
            end
        end
        addr_buf.push_back(eav_pkg::CH_AT);
        labels = $urandom_range(1, 3);
        for (i = 0; i < labels; i++) begin
            if (i > 0) begin
                addr_buf.push_back(eav_pkg::CH_DOT);
            end
            len = $urandom_range(1, 4);
            repeat (len) addr_buf.push_back(pick_atom_char());
        end
        if ($urandom_range(0, 7) == 0) begin
            addr_buf.push_back(eav_pkg::CH_DOT);
        end
        if (kind <= 3) begin
            pos = $urandom_range(0, addr_buf.size() - 1);
            case ($urandom_range(0, 4))
                0: addr_buf[pos] = 8'($urandom_range(1, 255));
                1: addr_buf.insert(pos, eav_pkg::CH_DOT);
                2: addr_buf.delete(pos);
                3: addr_buf.insert(pos, specials[$urandom_range(0, specials.len() - 1)]);
                default: begin
                    while (addr_buf.size() > pos) void'(addr_buf.pop_back());
                end
            endcase
        end
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : verdict_check
        logic want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            verdicts_seen++;
            if (m_address_ok === 1'b1) begin
                valid_seen++;
            end
            if (verdict_q.size() == 0) begin
                flag_failure($sformatf("verdict %0b with none expected", m_address_ok));
            end else begin
                want = verdict_q.pop_front();
                if (m_address_ok !== want) begin
                    flag_failure($sformatf("address_ok expected %0b, got %0b",
                                           want, m_address_ok));
                end
            end
        end
    end

    initial begin : stimulus
        string s;
        int    i;
        int    j;
        bit    hold_done;
        bit    pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            s = dir_text[i];
            addr_buf.delete();
            for (j = 0; j < s.len(); j++) begin
                addr_buf.push_back(s[j]);
            end
            send_address(dir_verdict[i]);
        end
        wait_for_verdicts();

        while (useful_bytes < ITEM_TARGET) begin
            if (!hold_done && useful_bytes >= ITEM_TARGET / 3) begin
                // Keep offering items while the receiver is stalled so the
                // block fills up and drops s_ready.
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (8) begin
                    compose_address();
                    send_address(USE_PREDICTION);
                end
            end
            if (!pause_done && useful_bytes >= (ITEM_TARGET * 2) / 3) begin
                pause_done = 1'b1;
                wait_for_verdicts();
            end
            if (useful_bytes >= (ITEM_TARGET * 7) / 8) begin
                idle_on = 1'b0;
            end
            compose_address();
            send_address(USE_PREDICTION);
        end

        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            flag_failure($sformatf("%0d verdicts never arrived", verdict_q.size()));
        end
        $display("Checked %0d verdicts (%0d valid addresses) over %0d input bytes,",
                 verdicts_seen, valid_seen, useful_bytes);
        $display("with quoted parts, escapes, early rejections and a long output stall.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule
